>>> rtl/core/lpht_pkg.sv
// lpht_pkg: shared types and constants of the linear probing hash table
// field widths, register indexes, request and status codes, controller states
// no dependencies
package lpht_pkg;

    localparam int KEY_W       = 31;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int SLOT_W      = 10;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_W     = KEY_W + 1;
    localparam int STEP_CNT_W  = $clog2(KEY_W);

    localparam int DEF_CAPACITY = 1024;

    localparam logic [CFG_W-1:0] RST_SLOTS_IN_USE = 11'd1024;
    localparam logic [CFG_W-1:0] RST_HASH_DIVISOR = 11'd1021;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_DIVISOR = 1'd1;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/lpht_if.sv
// lpht_req_if and lpht_rsp_if: valid/ready channels of the hash table
// depends on lpht_pkg for the field widths
interface lpht_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [lpht_pkg::KEY_W-1:0] key_value;

    modport source (output valid, output req_type, output key_value, input ready);
    modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface lpht_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [lpht_pkg::STATUS_W-1:0] status;
    logic [lpht_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

>>> rtl/core/lpht_mod_div.sv
// lpht_mod_div: restoring remainder unit, one dividend bit per cycle
// depends on lpht_pkg for the key and divisor widths
module lpht_mod_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lpht_pkg::KEY_W-1:0]  dividend,
    input  logic [lpht_pkg::CFG_W-1:0]  divisor,
    output logic                        done,
    output logic [lpht_pkg::CFG_W-1:0]  remainder
);

    localparam int KW = lpht_pkg::KEY_W;
    localparam int DW = lpht_pkg::CFG_W;
    localparam int CW = lpht_pkg::STEP_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] num_reg, num_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW:0]   trial;
    logic          last;

    assign trial = {rem_reg, num_reg[KW-1]};
    assign last  = (cnt_reg == CW'(KW - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[KW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
                rem_next = DW'(trial - {1'b0, den_reg});
            else
                rem_next = DW'(trial);
            cnt_next = cnt_reg + CW'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/core/lpht_slot_ram.sv
// lpht_slot_ram: slot memory, one write and one registered read per cycle
// each word holds a valid bit above the stored key; depends on lpht_pkg
module lpht_slot_ram #(
    parameter int DEPTH = lpht_pkg::DEF_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [lpht_pkg::ENTRY_W-1:0]  wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [lpht_pkg::ENTRY_W-1:0]  rdata
);

    logic [lpht_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [lpht_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/linear_probe_hash_table.sv
// linear_probe_hash_table: open-addressing hash table, division hash, linear probing
// depends on lpht_pkg, lpht_if, lpht_mod_div and lpht_slot_ram
//
// After reset the block clears every slot of the slot memory and takes
// no request meanwhile; configuration writes are taken at any time. A request then
// has the key modulo divisor worked out, one key bit per cycle, then probes
// the slots with one probe per cycle through the single read port of the slot
// memory, and then hands the result to the output register once that is free. A
// new request is taken while the previous result still waits at the output. Slot
// indexes above 1023 are reported in their low ten bits.
module linear_probe_hash_table #(
    parameter int CAPACITY = lpht_pkg::DEF_CAPACITY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lpht_req_if.sink                        req,
    lpht_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [lpht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpht_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int SW  = $clog2(CAPACITY + 1);
    localparam int FW  = lpht_pkg::CFG_W;
    localparam int CW  = (SW > FW) ? SW : FW;
    localparam int KW  = lpht_pkg::KEY_W;
    localparam int EW  = lpht_pkg::ENTRY_W;
    localparam int TW  = lpht_pkg::STATUS_W;
    localparam int OW  = lpht_pkg::SLOT_W;

    lpht_pkg::state_t state_reg, state_next;

    logic [FW-1:0] slots_in_use_reg, hash_divisor_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [KW-1:0] key_reg, key_next;
    logic          search_reg, search_next;
    logic [SW-1:0] size_reg, size_next;
    logic [FW-1:0] div_reg, div_next;
    logic [AW-1:0] home_reg, home_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [TW-1:0] res_status_reg, res_status_next;
    logic [OW-1:0] res_slot_reg, res_slot_next;
    logic          rsp_valid_reg;
    logic [TW-1:0] rsp_status_reg;
    logic [OW-1:0] rsp_slot_reg;

    logic          div_start, div_done;
    logic [FW-1:0] div_rem;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [CW-1:0] size_ext, cap_ext, dvs_ext;
    logic [SW-1:0] eff_size;
    logic [FW-1:0] eff_div;
    logic [SW-1:0] idx_inc;
    logic [AW-1:0] idx_wrap;
    logic          out_free;
    logic          rsp_load;

    // effective size and divisor from the configuration
    always_comb
    begin
        size_ext = CW'(slots_in_use_reg);
        cap_ext  = CW'(CAPACITY);
        if (size_ext == '0)
            size_ext = CW'(1);
        if (size_ext > cap_ext)
            size_ext = cap_ext;
        eff_size = SW'(size_ext);
        dvs_ext  = CW'(hash_divisor_reg);
        if (dvs_ext == '0)
            dvs_ext = CW'(1);
        if (dvs_ext > size_ext)
            dvs_ext = size_ext;
        eff_div = FW'(dvs_ext);
    end

    assign idx_inc  = SW'(idx_reg) + SW'(1);
    assign idx_wrap = (idx_inc >= size_reg) ? '0 : AW'(idx_inc);
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= lpht_pkg::RST_SLOTS_IN_USE;
            hash_divisor_reg <= lpht_pkg::RST_HASH_DIVISOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpht_pkg::CFG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data;
                lpht_pkg::CFG_HASH_DIVISOR: hash_divisor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        key_next        = key_reg;
        search_next     = search_reg;
        size_next       = size_reg;
        div_next        = div_reg;
        home_next       = home_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        req.ready       = 1'b0;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {1'b1, key_reg};
        ram_raddr       = idx_reg;
        rsp_load        = 1'b0;
        case (state_reg)
            lpht_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(CAPACITY - 1))
                    state_next = lpht_pkg::ST_IDLE;
            end
            lpht_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    key_next    = req.key_value;
                    search_next = (req.req_type == lpht_pkg::REQ_SEARCH);
                    size_next   = eff_size;
                    div_next    = eff_div;
                    div_start   = 1'b1;
                    state_next  = lpht_pkg::ST_HASH;
                end
            end
            lpht_pkg::ST_HASH:
            begin
                if (div_done)
                begin
                    home_next  = AW'(div_rem);
                    idx_next   = AW'(div_rem);
                    ram_raddr  = AW'(div_rem);
                    state_next = lpht_pkg::ST_PROBE;
                end
            end
            lpht_pkg::ST_PROBE:
            begin
                // the insert write lands long before the next request reads
                if (!ram_rdata[EW-1])
                begin
                    state_next = lpht_pkg::ST_DONE;
                    if (search_reg)
                    begin
                        res_status_next = lpht_pkg::STATUS_NOT_FOUND;
                        res_slot_next   = '0;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        res_status_next = lpht_pkg::STATUS_INSERTED;
                        res_slot_next   = OW'(idx_reg);
                    end
                end
                else if (search_reg && (ram_rdata[KW-1:0] == key_reg))
                begin
                    state_next      = lpht_pkg::ST_DONE;
                    res_status_next = lpht_pkg::STATUS_FOUND;
                    res_slot_next   = OW'(idx_reg);
                end
                else if (idx_wrap == home_reg)
                begin
                    state_next      = lpht_pkg::ST_DONE;
                    res_status_next = search_reg ? lpht_pkg::STATUS_NOT_FOUND
                                                 : lpht_pkg::STATUS_FULL;
                    res_slot_next   = '0;
                end
                else
                begin
                    idx_next  = idx_wrap;
                    ram_raddr = idx_wrap;
                end
            end
            lpht_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = lpht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpht_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        search_reg     <= search_next;
        size_reg       <= size_next;
        div_reg        <= div_next;
        home_reg       <= home_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_slot_reg   <= res_slot_reg;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.slot_index = rsp_slot_reg;

    lpht_mod_div u_mod_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (key_next),
        .divisor   (div_next),
        .done      (div_done),
        .remainder (div_rem)
    );

    lpht_slot_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> rtl/core/lpht_checker.sv
// lpht_checker: port-level assertions of the hash table, bound to the top level
// depends on lpht_pkg and linear_probe_hash_table
module lpht_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [lpht_pkg::STATUS_W-1:0]  status,
    input logic [lpht_pkg::SLOT_W-1:0]    slot_index
);

    logic [1:0] pending_reg;
    logic       req_acc, rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // transactions accepted and not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 2'(req_acc) - 2'(rsp_acc);
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot_index))
        else $error("result changed while stalled");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == lpht_pkg::STATUS_NOT_FOUND || status == lpht_pkg::STATUS_FULL)
        |-> slot_index == '0)
        else $error("nonzero slot index on miss or full");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request taken while previous one in progress");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted request");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .slot_index (rsp.slot_index)
);
